@@ hdl/ptca_pkg.sv @@
// ptca_pkg: shared types, codes and constants of the per-task cycle accounting block
// no dependencies; imported by per_task_cycle_accounting
package ptca_pkg;

   // default sizing, handed to the top level parameters
   localparam int TASK_SLOTS_DEF = 32;
   localparam int STAMP_BITS_DEF = 32;

   // fixed field widths
   localparam int FUNC_W   = 3;
   localparam int INDEX_W  = 6;
   localparam int TS_W     = 32;
   localparam int PERIOD_W = 33;
   localparam int TOTAL_W  = 64;
   localparam int STATUS_W = 2;
   localparam int NEST_W   = 8;

   localparam logic [INDEX_W-1:0]  NO_OWNER     = '1;
   localparam logic [NEST_W-1:0]   NEST_MAX     = '1;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = {1'b1, {(PERIOD_W-1){1'b0}}};

   typedef enum logic [FUNC_W-1:0] {
      FN_SWITCH    = 3'd0,
      FN_SYS_ENTER = 3'd1,
      FN_SYS_EXIT  = 3'd2,
      FN_START     = 3'd3,
      FN_STOP      = 3'd4,
      FN_READ      = 3'd5
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_IGNORED   = 2'd1,
      ST_REFUSED   = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SQ_IDLE  = 2'd0,
      SQ_READ  = 2'd1,
      SQ_WRITE = 2'd2
   } seq_type;

endpackage

@@ hdl/ptca_ram.sv @@
// ptca_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies; used for the total and start-stamp tables
module ptca_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 33,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/per_task_cycle_accounting.sv @@
// per_task_cycle_accounting: top level, command sequencer around the total and stamp tables
// depends on ptca_pkg and ptca_ram
//
// Usage
//  - a command word (req_func, req_task_index, req_timestamp) is taken at a rising
//    edge with start high and busy low
//  - each command gives exactly one result word: rsp_status and rsp_read_value are
//    shown for one cycle with rsp_valid high, as the sequencer returns to idle;
//    the receiver cannot stall, so the word must be taken then
//  - an item is handled in steps: the old owner's stamp and total are read from the
//    tables at the accept edge, the elapsed time is formed in the read state, and it
//    is added and written back in the write state; busy is high in the read and write
//    states, so a new word is taken only back in idle, in the same cycle a result is shown
//  - the tables are touched by one read-modify-write per item, so no forwarding is
//    needed
//  - csr_stamp_period sets the timestamp wrap modulus; write it only while idle
//  - reset is synchronous: the window is closed, no owner, nesting zero, all totals
//    read as zero (valid bits, no clearing pass) and the period returns to 2^32
module per_task_cycle_accounting #(
   parameter int TASK_SLOTS = ptca_pkg::TASK_SLOTS_DEF,
   parameter int STAMP_BITS = ptca_pkg::STAMP_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [ptca_pkg::FUNC_W-1:0]    req_func,
   input  logic [ptca_pkg::INDEX_W-1:0]   req_task_index,
   input  logic [ptca_pkg::TS_W-1:0]      req_timestamp,
   output logic                           rsp_valid,
   output logic [ptca_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ptca_pkg::TOTAL_W-1:0]   rsp_read_value,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ptca_pkg::PERIOD_W-1:0]  csr_stamp_period
);
   import ptca_pkg::*;

   localparam int ENTRIES = TASK_SLOTS + 1;
   localparam int AW      = $clog2(ENTRIES);
   localparam int STAMP_W = (STAMP_BITS < TS_W) ? STAMP_BITS : TS_W;
   localparam int EW      = PERIOD_W + 2;
   localparam logic [INDEX_W-1:0] SYS_IDX = INDEX_W'(TASK_SLOTS);

   // sequencer and configuration
   seq_type                 state_ff, state_in;
   logic [PERIOD_W-1:0]     period_ff;

   // latched command word
   func_type                func_ff;
   logic [INDEX_W-1:0]      idx_ff;
   logic [STAMP_W-1:0]      ts_ff;

   // accounting state
   logic                    counting_ff, done_ff;
   logic [NEST_W-1:0]       nest_ff;
   logic [INDEX_W-1:0]      owner_ff;
   logic [ENTRIES-1:0]      started_ff;
   logic [ENTRIES-1:0]      valid_ff;

   // decisions taken in the read cycle
   status_type              status_ff, status_in;
   logic                    take_ff, take_in;
   logic                    charge_ff, charge_in;
   logic                    read_ok_ff, read_ok_in;
   logic [AW-1:0]           target_ff, target_in;
   logic [NEST_W-1:0]       nest_next_ff, nest_next_in;
   logic [EW-1:0]           elapsed_ff, elapsed_in;

   // result word
   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [TOTAL_W-1:0]      rsp_value_ff;

   // table ports
   logic                    accept;
   logic [AW-1:0]           owner_addr, idx_addr, total_raddr;
   logic [TOTAL_W-1:0]      total_q, total_cur, total_sum;
   logic [STAMP_W-1:0]      stamp_q;
   logic                    total_we, stamp_we;
   logic                    take_raw;
   logic [INDEX_W-1:0]      target_raw;
   logic [NEST_W-1:0]       nest_dec;

   assign accept     = start && !busy;
   assign busy       = (state_ff != SQ_IDLE);
   assign csr_ready  = 1'b1;
   assign owner_addr = (owner_ff != NO_OWNER) ? owner_ff[AW-1:0] : '0;
   assign idx_addr   = idx_ff[AW-1:0];

   // total table address: read target on reads, current owner otherwise
   always_comb begin
      total_raddr = owner_addr;
      if ((func_type'(req_func) == FN_READ) && (req_task_index <= SYS_IDX)) begin
         total_raddr = req_task_index[AW-1:0];
      end
   end

   ptca_ram #(.WIDTH(TOTAL_W), .DEPTH(ENTRIES)) u_total_ram (
      .clock (clock),
      .we    (total_we),
      .waddr (owner_addr),
      .wdata (total_sum),
      .re    (accept),
      .raddr (total_raddr),
      .rdata (total_q)
   );

   ptca_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRIES)) u_stamp_ram (
      .clock (clock),
      .we    (stamp_we),
      .waddr (target_ff),
      .wdata (ts_ff),
      .re    (accept),
      .raddr (owner_addr),
      .rdata (stamp_q)
   );

   // add of the elapsed time onto the owner's total
   assign total_cur = valid_ff[owner_addr] ? total_q : '0;
   assign total_sum = total_cur + {{(TOTAL_W-EW){elapsed_ff[EW-1]}}, elapsed_ff};
   assign total_we  = (state_ff == SQ_WRITE) && charge_ff;
   assign stamp_we  = (state_ff == SQ_WRITE) && take_ff;

   // next state and read-cycle decisions
   always_comb begin
      state_in     = state_ff;
      status_in    = ST_DONE;
      take_raw     = 1'b0;
      target_raw   = idx_ff;
      read_ok_in   = 1'b0;
      nest_next_in = nest_ff;
      nest_dec     = nest_ff - NEST_W'(nest_ff != '0);
      unique case (state_ff)
         SQ_IDLE:  if (accept) state_in = SQ_READ;
         SQ_READ:  state_in = SQ_WRITE;
         SQ_WRITE: state_in = SQ_IDLE;
         default:  state_in = SQ_IDLE;
      endcase
      unique case (func_ff)
         FN_SWITCH: begin
            if (!counting_ff) status_in = ST_IGNORED;
            else if (idx_ff >= SYS_IDX) status_in = ST_BAD_INDEX;
            else take_raw = 1'b1;
         end
         FN_SYS_ENTER: begin
            if (!counting_ff) begin
               status_in = ST_IGNORED;
            end else begin
               if (nest_ff != NEST_MAX) nest_next_in = nest_ff + 1'b1;
               take_raw   = 1'b1;
               target_raw = SYS_IDX;
            end
         end
         FN_SYS_EXIT: begin
            if (!counting_ff) begin
               status_in = ST_IGNORED;
            end else begin
               nest_next_in = nest_dec;
               if (nest_dec == '0) begin
                  if (idx_ff >= SYS_IDX) status_in = ST_BAD_INDEX;
                  else take_raw = 1'b1;
               end
            end
         end
         FN_START: begin
            nest_next_in = '0;
         end
         FN_READ: begin
            if (counting_ff || !done_ff) status_in = ST_REFUSED;
            else if (idx_ff > SYS_IDX) status_in = ST_BAD_INDEX;
            else read_ok_in = 1'b1;
         end
         default: ;
      endcase
      take_in   = take_raw && (target_raw != owner_ff);
      target_in = target_raw[AW-1:0];
      charge_in = take_in && (owner_ff != NO_OWNER) && started_ff[owner_addr];
   end

   // elapsed time since the owner's stamp, with wrap at the period
   always_comb begin
      elapsed_in = EW'(ts_ff) - EW'(stamp_q);
      if (ts_ff < stamp_q) begin
         elapsed_in = elapsed_in + EW'(period_ff);
      end
   end

   // sequencer and configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= SQ_IDLE;
         period_ff <= PERIOD_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) period_ff <= csr_stamp_period;
      end
   end

   // command latch and read-cycle pipeline registers
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= func_type'(req_func);
         idx_ff  <= req_task_index;
         ts_ff   <= req_timestamp[STAMP_W-1:0];
      end
      if (state_ff == SQ_READ) begin
         status_ff    <= status_in;
         take_ff      <= take_in;
         charge_ff    <= charge_in;
         read_ok_ff   <= read_ok_in;
         target_ff    <= target_in;
         nest_next_ff <= nest_next_in;
         elapsed_ff   <= elapsed_in;
      end
   end

   // accounting state update in the write cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         counting_ff <= 1'b0;
         done_ff     <= 1'b0;
         nest_ff     <= '0;
         owner_ff    <= NO_OWNER;
         started_ff  <= '0;
         valid_ff    <= '0;
      end else if (state_ff == SQ_WRITE) begin
         nest_ff <= nest_next_ff;
         if (charge_ff) valid_ff[owner_addr] <= 1'b1;
         if (take_ff) begin
            started_ff[target_ff] <= 1'b1;
            owner_ff              <= INDEX_W'(target_ff);
         end
         if (func_ff == FN_START) begin
            counting_ff <= 1'b1;
            done_ff     <= 1'b0;
            owner_ff    <= NO_OWNER;
            started_ff  <= '0;
            valid_ff    <= '0;
         end else if (func_ff == FN_STOP) begin
            counting_ff <= 1'b0;
            done_ff     <= 1'b1;
         end
      end
   end

   // result word, one cycle strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == SQ_WRITE);
      end
      if (state_ff == SQ_WRITE) begin
         rsp_status_ff <= status_ff;
         rsp_value_ff  <= (read_ok_ff && valid_ff[idx_addr]) ? total_q : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;

   // every accepted word gives its result word
   assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid)
      else $error("result word missing after accept");

   // a result only follows the write cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == SQ_WRITE))
      else $error("result word without write cycle");

   // window cannot be open and closed at once
   assert property (@(posedge clock) disable iff (reset)
      !(counting_ff && done_ff))
      else $error("counting window both open and done");

   // a current owner always carries a start stamp
   assert property (@(posedge clock) disable iff (reset)
      (owner_ff != NO_OWNER) |-> started_ff[owner_ff[AW-1:0]])
      else $error("owner without start stamp");

   // charging only happens against a real owner
   assert property (@(posedge clock) disable iff (reset)
      total_we |-> (owner_ff != NO_OWNER))
      else $error("total written with no owner");

endmodule
